/* rtl/sdi_pkg.sv */
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the signed distance interval block.
// ----------------------------------------------------------------------------
package sdi_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CFG_INDEX_W     = 3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WHOLE_SPACE      = 3'd0,
    CFG_CONSTRAINT_COUNT = 3'd1,
    CFG_FIRST_BOUND      = 3'd2,
    CFG_FIRST_IS_UPPER   = 3'd3,
    CFG_SECOND_BOUND     = 3'd4,
    CFG_SECOND_IS_UPPER  = 3'd5,
    CFG_STRICT           = 3'd6
  } cfg_reg_e;

  localparam logic [1:0] COUNT_TWO = 2'd2;

  // decoded control bits of the set description
  typedef struct packed {
    logic whole_space;
    logic two;
    logic first_is_upper;
    logic second_is_upper;
    logic strict;
  } cfg_flags_t;

endpackage

/* rtl/sdi_cfg.sv */
// ----------------------------------------------------------------------------
// sdi_cfg
// Configuration register file; bounds are handed on in offset-binary form.
// ----------------------------------------------------------------------------
module sdi_cfg #(
  parameter int unsigned VALUE_WIDTH = sdi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdi_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]        cfg_wdata_i,
  output sdi_pkg::cfg_flags_t           flags_o,
  output logic [VALUE_WIDTH-1:0]        first_bias_o,
  output logic [VALUE_WIDTH-1:0]        second_bias_o
);

  logic                   whole_space_q;
  logic [1:0]             count_q;
  logic [VALUE_WIDTH-1:0] first_bound_q;
  logic                   first_is_upper_q;
  logic [VALUE_WIDTH-1:0] second_bound_q;
  logic                   second_is_upper_q;
  logic                   strict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_space_q     <= 1'b0;
      count_q           <= 2'd1;
      first_bound_q     <= '0;
      first_is_upper_q  <= 1'b1;
      second_bound_q    <= '0;
      second_is_upper_q <= 1'b0;
      strict_q          <= 1'b0;
    end else if (cfg_we_i) begin
      case (sdi_pkg::cfg_reg_e'(cfg_index_i))
        sdi_pkg::CFG_WHOLE_SPACE:      whole_space_q     <= cfg_wdata_i[0];
        sdi_pkg::CFG_CONSTRAINT_COUNT: count_q           <= cfg_wdata_i[1:0];
        sdi_pkg::CFG_FIRST_BOUND:      first_bound_q     <= cfg_wdata_i;
        sdi_pkg::CFG_FIRST_IS_UPPER:   first_is_upper_q  <= cfg_wdata_i[0];
        sdi_pkg::CFG_SECOND_BOUND:     second_bound_q    <= cfg_wdata_i;
        sdi_pkg::CFG_SECOND_IS_UPPER:  second_is_upper_q <= cfg_wdata_i[0];
        sdi_pkg::CFG_STRICT:           strict_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    flags_o.whole_space     = whole_space_q;
    flags_o.two             = (count_q == sdi_pkg::COUNT_TWO);
    flags_o.first_is_upper  = first_is_upper_q;
    flags_o.second_is_upper = second_is_upper_q;
    flags_o.strict          = strict_q;
  end

  // offset binary: unsigned order matches signed order
  assign first_bias_o  = {~first_bound_q[VALUE_WIDTH-1], first_bound_q[VALUE_WIDTH-2:0]};
  assign second_bias_o = {~second_bound_q[VALUE_WIDTH-1], second_bound_q[VALUE_WIDTH-2:0]};

endmodule

/* rtl/sdi_end.sv */
// ----------------------------------------------------------------------------
// sdi_end
// Signed distance of one interval end to the set, over two register stages.
// ----------------------------------------------------------------------------
module sdi_end #(
  parameter int unsigned VALUE_WIDTH = sdi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_a_i,
  input  logic                          en_b_i,
  input  logic [VALUE_WIDTH-1:0]        x_i,
  input  logic [VALUE_WIDTH-1:0]        b0_i,
  input  logic [VALUE_WIDTH-1:0]        b1_i,
  input  sdi_pkg::cfg_flags_t           flags_i,
  output logic signed [VALUE_WIDTH-1:0] dist_o
);

  localparam logic [VALUE_WIDTH-1:0] MaxV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic [VALUE_WIDTH-1:0] gap0_d, gap1_d, gap0_q, gap1_q;
  logic                   in0, in1, inside_d, inside_q;
  logic [VALUE_WIDTH-1:0] near, mag, dist_d;
  logic [VALUE_WIDTH-1:0] dist_q;

  // stage a: gaps to both boundaries and membership
  always_comb begin
    gap0_d = (x_i >= b0_i) ? (x_i - b0_i) : (b0_i - x_i);
    gap1_d = (x_i >= b1_i) ? (x_i - b1_i) : (b1_i - x_i);
    if (flags_i.strict) begin
      in0 = flags_i.first_is_upper  ? (x_i < b0_i) : (x_i > b0_i);
      in1 = flags_i.second_is_upper ? (x_i < b1_i) : (x_i > b1_i);
    end else begin
      in0 = flags_i.first_is_upper  ? (x_i <= b0_i) : (x_i >= b0_i);
      in1 = flags_i.second_is_upper ? (x_i <= b1_i) : (x_i >= b1_i);
    end
    inside_d = in0 && (!flags_i.two || in1);
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      gap0_q   <= gap0_d;
      gap1_q   <= gap1_d;
      inside_q <= inside_d;
    end
  end

  // stage b: nearest boundary, saturate, apply sign
  always_comb begin
    near   = (flags_i.two && (gap1_q < gap0_q)) ? gap1_q : gap0_q;
    mag    = near[VALUE_WIDTH-1] ? MaxV : near;
    dist_d = inside_q ? mag : (~mag + 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = $signed(dist_q);

endmodule

/* rtl/sdi_mid.sv */
// ----------------------------------------------------------------------------
// sdi_mid
// Midpoint rule: decides whether the boundary midpoint overrides the upper
// result, and carries the half-width, over two register stages.
// ----------------------------------------------------------------------------
module sdi_mid #(
  parameter int unsigned VALUE_WIDTH = sdi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_a_i,
  input  logic                   en_b_i,
  input  logic [VALUE_WIDTH-1:0] up_i,
  input  logic [VALUE_WIDTH-1:0] lo_i,
  input  logic [VALUE_WIDTH-1:0] b0_i,
  input  logic [VALUE_WIDTH-1:0] b1_i,
  input  sdi_pkg::cfg_flags_t    flags_i,
  output logic                   take_o,
  output logic [VALUE_WIDTH-1:0] half_width_o
);

  logic [VALUE_WIDTH-1:0] mid, span;
  logic                   half, in0, in1, above_lo, below_up;
  logic                   take_d, take_a_q, take_b_q;
  logic [VALUE_WIDTH-1:0] hw_d, hw_a_q, hw_b_q;

  // exact midpoint is mid plus half an lsb when half is set
  always_comb begin
    mid  = (b0_i >> 1) + (b1_i >> 1) + {{(VALUE_WIDTH-1){1'b0}}, b0_i[0] & b1_i[0]};
    half = b0_i[0] ^ b1_i[0];
    in0  = flags_i.first_is_upper  ? (mid < b0_i) : (half ? (mid >= b0_i) : (mid > b0_i));
    in1  = flags_i.second_is_upper ? (mid < b1_i) : (half ? (mid >= b1_i) : (mid > b1_i));
    above_lo = half ? (mid >= lo_i) : (mid > lo_i);
    below_up = mid < up_i;
    take_d   = in0 && in1 && above_lo && below_up;
    span     = (b0_i >= b1_i) ? (b0_i - b1_i) : (b1_i - b0_i);
    hw_d     = span >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      take_a_q <= take_d;
      hw_a_q   <= hw_d;
    end
    if (en_b_i) begin
      take_b_q <= take_a_q;
      hw_b_q   <= hw_a_q;
    end
  end

  assign take_o       = take_b_q;
  assign half_width_o = hw_b_q;

endmodule

/* rtl/signed_distance_interval_1d.sv */
// Each accepted transaction passes the gap, distance and ordering registers in that order.
// One transaction per cycle unless stalled; gap, distance and ordering stages each hold one.
// A stalled output fills empty stages first; input ready drops only when all stages are full.
// Reset clears the stage valid bits and puts the configuration registers at their defaults.
// ----------------------------------------------------------------------------
// signed_distance_interval_1d
// Signed robustness interval of one signal dimension against a set bounded
// by one or two half-lines, three-stage pipeline with valid/ready channels.
// ----------------------------------------------------------------------------
module signed_distance_interval_1d #(
  parameter int unsigned VALUE_WIDTH = sdi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]   upper_value_i,
  input  logic signed [VALUE_WIDTH-1:0]   lower_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]   robust_upper_o,
  output logic signed [VALUE_WIDTH-1:0]   robust_lower_o,
  input  logic                            cfg_we_i,
  input  logic [sdi_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]          cfg_wdata_i
);

  localparam logic [VALUE_WIDTH-1:0] MaxV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  sdi_pkg::cfg_flags_t    flags;
  logic [VALUE_WIDTH-1:0] b0, b1, up_b, lo_b;
  logic                   v1_q, v2_q, out_valid_q;
  logic                   adv1, adv2, adv3;
  logic                   eq1_q, eq2_q;
  logic signed [VALUE_WIDTH-1:0] du, dl;
  logic                   take;
  logic [VALUE_WIDTH-1:0] half_width;
  logic [VALUE_WIDTH-1:0] ru_d, rl_d, ru_q, rl_q;

  sdi_cfg #(.VALUE_WIDTH(VALUE_WIDTH)) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .flags_o       (flags),
    .first_bias_o  (b0),
    .second_bias_o (b1)
  );

  assign up_b = {~upper_value_i[VALUE_WIDTH-1], upper_value_i[VALUE_WIDTH-2:0]};
  assign lo_b = {~lower_value_i[VALUE_WIDTH-1], lower_value_i[VALUE_WIDTH-2:0]};

  // a stage moves when it is empty or the next one moves
  assign adv3       = !out_valid_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) v1_q        <= in_valid_i;
      if (adv2) v2_q        <= v1_q;
      if (adv3) out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) eq1_q <= (upper_value_i == lower_value_i);
    if (adv2) eq2_q <= eq1_q;
  end

  sdi_end #(.VALUE_WIDTH(VALUE_WIDTH)) u_end_up (
    .clk_i   (clk_i),
    .en_a_i  (adv1),
    .en_b_i  (adv2),
    .x_i     (up_b),
    .b0_i    (b0),
    .b1_i    (b1),
    .flags_i (flags),
    .dist_o  (du)
  );

  sdi_end #(.VALUE_WIDTH(VALUE_WIDTH)) u_end_lo (
    .clk_i   (clk_i),
    .en_a_i  (adv1),
    .en_b_i  (adv2),
    .x_i     (lo_b),
    .b0_i    (b0),
    .b1_i    (b1),
    .flags_i (flags),
    .dist_o  (dl)
  );

  sdi_mid #(.VALUE_WIDTH(VALUE_WIDTH)) u_mid (
    .clk_i        (clk_i),
    .en_a_i       (adv1),
    .en_b_i       (adv2),
    .up_i         (up_b),
    .lo_i         (lo_b),
    .b0_i         (b0),
    .b1_i         (b1),
    .flags_i      (flags),
    .take_o       (take),
    .half_width_o (half_width)
  );

  // ordering stage
  always_comb begin
    if (flags.whole_space) begin
      ru_d = MaxV;
      rl_d = MaxV;
    end else if (eq2_q) begin
      ru_d = du;
      rl_d = du;
    end else begin
      if (du > dl) begin
        ru_d = du;
        rl_d = dl;
      end else begin
        ru_d = dl;
        rl_d = du;
      end
      if (flags.two && take) begin
        ru_d = half_width;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ru_q <= ru_d;
      rl_q <= rl_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign robust_upper_o = $signed(ru_q);
  assign robust_lower_o = $signed(rl_q);

  // results are never the most negative code
  a_no_min_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rl_q != {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
    else $error("robust_lower at most negative code");

  a_no_min_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ru_q != {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
    else $error("robust_upper at most negative code");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && out_valid_q))
    else $error("input blocked with an empty stage");

  a_mid_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv3) |=> v2_q)
    else $error("stalled transaction lost from middle stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !v2_q) |=> !out_valid_q)
    else $error("result repeated after transaction taken");

endmodule
